// ===== rtl/spf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants for the path flattener
// Command codes and fixed-point constants.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int unsigned MAX_CURVE_POINTS_DEF = 64;
	localparam int unsigned COORD_BITS_DEF       = 32;
	localparam int unsigned T_BITS               = 17;
	localparam logic [T_BITS-1:0] ONE_Q16        = 17'h10000;
	localparam logic [T_BITS-1:0] T_STEP_RESET   = 17'd6554;
	localparam int unsigned OP_BITS              = 4;
	localparam int unsigned COLOUR_BITS          = 24;
	localparam int unsigned VAL_BITS             = 32;

	typedef enum logic [OP_BITS-1:0] {
		OP_MOVE   = 4'd0,
		OP_LINE   = 4'd1,
		OP_HORIZ  = 4'd2,
		OP_VERT   = 4'd3,
		OP_CLOSE  = 4'd4,
		OP_CUBIC  = 4'd5,
		OP_SCUBIC = 4'd6,
		OP_QUAD   = 4'd7,
		OP_SQUAD  = 4'd8
	} op_t;

endpackage

// ===== rtl/svg_path_flattener.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svg_path_flattener: path command to point stream
// Converts one path command per beat into line or Bezier points.
// ----------------------------------------------------------------------------
// A line-type command yields one point; it passes through accept, prepare
// and output, and the output holds until the beat is taken. A curve
// yields one point for each multiple of t_step up to 1.0 (at most
// MAX_CURVE_POINTS); each point is evaluated by de Casteljau on one shared
// two-stage interpolation unit: 12 lerps for a cubic, 6 for a quadratic.
// Each command has a prepare step; each curve point steps t, runs its
// lerps in turn and is then output, held while the receiver holds off.
// The input is not ready while a command is being worked on.
module svg_path_flattener
	import spf_pkg::*;
#(
	parameter int unsigned MAX_CURVE_POINTS = MAX_CURVE_POINTS_DEF,
	parameter int unsigned COORD_BITS       = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [T_BITS-1:0]  cfg_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// tdata: colour[23:0], value0..value5 [215:24]
	input  logic [215:0]       s_axis_tdata,
	// tuser: operation[3:0], absolute flag[4]
	input  logic [4:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// tdata: point_x[31:0], point_y[63:32], point_colour[87:64]
	output logic [87:0]        m_axis_tdata,
	// tuser: pen_down
	output logic               m_axis_tuser,
	// tlast: last_point
	output logic               m_axis_tlast
);

	localparam int unsigned W  = COORD_BITS;
	localparam int unsigned KW = $clog2(MAX_CURVE_POINTS + 1);
	localparam int unsigned TW = T_BITS + KW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_LERP, ST_WAIT, ST_OUT, ST_NEXT
	} state_t;

	state_t                 state_q;
	logic [T_BITS-1:0]      t_step_q;
	logic signed [W-1:0]    cur_x_q, cur_y_q, sub_x_q, sub_y_q, ctl_x_q, ctl_y_q;
	logic signed [W-1:0]    p_q [8];  // x0 y0 x1 y1 x2 y2 x3 y3
	logic signed [W-1:0]    r_q [10]; // intermediate lerp results
	logic [3:0]             step_q;
	logic                   cubic_q;
	logic [KW-1:0]          k_q;
	logic [TW-1:0]          t_q;
	logic [OP_BITS-1:0]     op_q;
	logic                   abs_q;
	logic [COLOUR_BITS-1:0] colour_q;
	logic [VAL_BITS-1:0]    v_q [6];
	logic signed [W-1:0]    ox, oy, vv [6];
	logic signed [W-1:0]    la, lb, lres;
	logic                   lstart, ldone;
	logic [TW-1:0]          t_next;
	logic                   more;
	logic [31:0]            ox32, oy32;
	logic signed [W-1:0]    out_x_q, out_y_q;
	logic                   pen_q, last_q;

	assign s_axis_tready = (state_q == ST_IDLE);

	// relative offset and sign-extended values
	always_comb begin
		ox = abs_q ? '0 : cur_x_q;
		oy = abs_q ? '0 : cur_y_q;
		for (int i = 0; i < 6; i++) begin
			vv[i] = W'($signed(v_q[i]));
		end
	end

	// lerp operand select per schedule step
	// cubic: 0-5 first level (ax ay bx by cx cy), 6-9 second, 10-11 final
	// quad: 0-3 first level (ax ay bx by), 4-5 final
	always_comb begin
		la = '0;
		lb = '0;
		if (cubic_q) begin
			case (step_q)
				4'd0:  begin la = p_q[0]; lb = p_q[2]; end
				4'd1:  begin la = p_q[1]; lb = p_q[3]; end
				4'd2:  begin la = p_q[2]; lb = p_q[4]; end
				4'd3:  begin la = p_q[3]; lb = p_q[5]; end
				4'd4:  begin la = p_q[4]; lb = p_q[6]; end
				4'd5:  begin la = p_q[5]; lb = p_q[7]; end
				4'd6:  begin la = r_q[0]; lb = r_q[2]; end
				4'd7:  begin la = r_q[1]; lb = r_q[3]; end
				4'd8:  begin la = r_q[2]; lb = r_q[4]; end
				4'd9:  begin la = r_q[3]; lb = r_q[5]; end
				4'd10: begin la = r_q[6]; lb = r_q[8]; end
				4'd11: begin la = r_q[7]; lb = r_q[9]; end
				default: ;
			endcase
		end else begin
			case (step_q)
				4'd0: begin la = p_q[0]; lb = p_q[2]; end
				4'd1: begin la = p_q[1]; lb = p_q[3]; end
				4'd2: begin la = p_q[2]; lb = p_q[6]; end
				4'd3: begin la = p_q[3]; lb = p_q[7]; end
				4'd4: begin la = r_q[0]; lb = r_q[2]; end
				4'd5: begin la = r_q[1]; lb = r_q[3]; end
				default: ;
			endcase
		end
	end

	assign lstart = (state_q == ST_LERP);

	spf_lerp #(.W(W)) u_lerp (
		.clk   (clk),
		.start (lstart),
		.a     (la),
		.b     (lb),
		.t     (t_q[T_BITS-1:0]),
		.done  (ldone),
		.res   (lres)
	);

	assign t_next = t_q + TW'(t_step_q);
	assign more   = (k_q < KW'(MAX_CURVE_POINTS)) && (t_next <= TW'(ONE_Q16));

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign ox32 = 32'(out_x_q);
	assign oy32 = 32'(out_y_q);
	assign m_axis_tdata  = {colour_q, oy32, ox32};
	assign m_axis_tuser  = pen_q;
	assign m_axis_tlast  = last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			t_step_q <= T_STEP_RESET;
			cur_x_q  <= '0; cur_y_q <= '0;
			sub_x_q  <= '0; sub_y_q <= '0;
			ctl_x_q  <= '0; ctl_y_q <= '0;
			step_q   <= '0;
			k_q      <= '0;
			t_q      <= '0;
			cubic_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				t_step_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q     <= s_axis_tuser[3:0];
						abs_q    <= s_axis_tuser[4];
						colour_q <= s_axis_tdata[23:0];
						for (int i = 0; i < 6; i++) begin
							v_q[i] <= s_axis_tdata[24 + 32*i +: 32];
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// only a moveto point is emitted with the pen up
					pen_q  <= (op_q != OP_MOVE);
					last_q <= 1'b1;
					case (op_q)
						OP_MOVE, OP_LINE, OP_HORIZ, OP_VERT, OP_CLOSE: begin
							logic signed [W-1:0] nx, ny;
							nx = vv[0] + ox;
							ny = vv[1] + oy;
							if (op_q == OP_HORIZ) ny = cur_y_q;
							if (op_q == OP_VERT) begin
								nx = cur_x_q;
								ny = vv[0] + oy;
							end
							if (op_q == OP_CLOSE) begin
								nx = sub_x_q;
								ny = sub_y_q;
							end
							if (op_q == OP_MOVE) begin
								sub_x_q <= nx;
								sub_y_q <= ny;
							end
							cur_x_q <= nx; cur_y_q <= ny;
							ctl_x_q <= nx; ctl_y_q <= ny;
							out_x_q <= nx; out_y_q <= ny;
							state_q <= ST_OUT;
						end
						OP_CUBIC, OP_SCUBIC, OP_QUAD, OP_SQUAD: begin
							logic signed [W-1:0] ax, ay, bx, by, nx, ny;
							logic                cub;
							cub = (op_q == OP_CUBIC) || (op_q == OP_SCUBIC);
							ax = (cur_x_q <<< 1) - ctl_x_q;
							ay = (cur_y_q <<< 1) - ctl_y_q;
							bx = vv[0] + ox; by = vv[1] + oy;
							nx = vv[2] + ox; ny = vv[3] + oy;
							if (op_q == OP_CUBIC) begin
								ax = vv[0] + ox; ay = vv[1] + oy;
								bx = vv[2] + ox; by = vv[3] + oy;
								nx = vv[4] + ox; ny = vv[5] + oy;
							end
							if (op_q == OP_SQUAD) begin
								bx = ax; by = ay;
								nx = vv[0] + ox; ny = vv[1] + oy;
							end
							cubic_q <= cub;
							p_q[0] <= cur_x_q; p_q[1] <= cur_y_q;
							if (cub) begin
								p_q[2] <= ax; p_q[3] <= ay;
								p_q[4] <= bx; p_q[5] <= by;
							end else begin
								p_q[2] <= bx; p_q[3] <= by;
							end
							p_q[6] <= nx; p_q[7] <= ny;
							cur_x_q <= nx; cur_y_q <= ny;
							ctl_x_q <= bx; ctl_y_q <= by;
							k_q     <= '0;
							t_q     <= '0;
							state_q <= ST_NEXT;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_NEXT: begin
					if (more) begin
						k_q     <= k_q + KW'(1);
						t_q     <= t_next;
						step_q  <= '0;
						state_q <= ST_LERP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LERP: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (ldone) begin
						if ((cubic_q && step_q == 4'd10) || (!cubic_q && step_q == 4'd4)) begin
							out_x_q <= lres;
						end else if ((cubic_q && step_q == 4'd11)
							|| (!cubic_q && step_q == 4'd5)) begin
							out_y_q <= lres;
						end else begin
							r_q[step_q] <= lres;
						end
						if ((cubic_q && step_q == 4'd11) || (!cubic_q && step_q == 4'd5)) begin
							last_q  <= !((k_q < KW'(MAX_CURVE_POINTS))
								&& (t_q + TW'(t_step_q) <= TW'(ONE_Q16)));
							state_q <= ST_OUT;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= ST_LERP;
						end
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						state_q <= last_q ? ST_IDLE : ST_NEXT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the output beat only appears outside the idle state
	a_out_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("output while idle");
	// a held output beat keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> $stable({m_axis_tlast, m_axis_tuser, m_axis_tdata}))
		else $error("output changed while stalled");
	// point count never exceeds the cap
	a_k_cap: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KW'(MAX_CURVE_POINTS)) else $error("point count overflow");

endmodule

// ===== rtl/spf_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_lerp: shared interpolation unit
// Computes a + round((b - a) * t / 65536), half up, wrapped to W bits.
// Two stages: difference and product are registered, then the sum.
// ----------------------------------------------------------------------------
module spf_lerp
	import spf_pkg::*;
#(
	parameter int unsigned W = COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  logic [T_BITS-1:0]   t,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int unsigned PW = W + 1 + T_BITS + 1;

	logic signed [W-1:0]  a_s1;
	logic signed [PW-1:0] prod_s1;
	logic                 done_q;
	logic signed [PW-1:0] rounded;

	// stage 1: wide difference times t
	always_ff @(posedge clk) begin
		a_s1    <= a;
		prod_s1 <= PW'($signed({b[W-1], b}) - $signed({a[W-1], a}))
			* $signed({1'b0, t});
		done_q  <= start;
	end

	// stage 2: round half up (floor of prod + 2^15 over 2^16)
	assign rounded = (prod_s1 + PW'(32768)) >>> 16;
	assign res     = a_s1 + W'(rounded);
	assign done    = done_q;

endmodule

// ===== bench/svg_path_flattener_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svg_path_flattener_tb: self-checking bench for the path flattener
// Drives path commands on the input stream, computes the expected point
// stream with an internal Q16.16 de Casteljau model, and compares every
// output beat field by field. The t_step register is changed between phases.
// ----------------------------------------------------------------------------
module svg_path_flattener_tb
	import spf_pkg::*;
();

	localparam int N_RANDOM  = 410;
	localparam int CYCLE_CAP = 5000000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [23:0] colour;
		logic        pen;
		logic        last;
	} point_t;

	typedef struct {
		logic [3:0]  op;
		logic        absolute;
		logic [23:0] colour;
		logic [31:0] v [6];
	} cmd_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [T_BITS-1:0]  cfg_wdata;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [215:0]       s_axis_tdata;
	logic [4:0]         s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [87:0]        m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;

	// model state
	logic signed [31:0] cur_x, cur_y, start_x, start_y, ctl_x, ctl_y;
	logic [16:0]        step_q16;

	point_t expected_points [$];
	int     mismatches;
	int     cycles;
	int     accept_base;
	bit     rx_hold;
	bit     rx_no_idle;
	bit     tx_no_idle;
	bit     done;

	svg_path_flattener dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// a + round((b - a) * t), half up; 64-bit intermediate
	function automatic logic signed [63:0] lerp_q16(logic signed [63:0] a,
			logic signed [63:0] b, logic [16:0] t);
		logic signed [63:0] d, lo, hi, frac;
		d = b - a;
		lo = {48'd0, d[15:0]};
		hi = (d - lo) >>> 16;
		frac = (lo * $signed({47'd0, t}) + 64'sd32768) >>> 16;
		return a + hi * $signed({47'd0, t}) + frac;
	endfunction

	task automatic bezier_points(bit cubic, logic [23:0] colour,
			logic signed [31:0] x0, y0, x1, y1, x2, y2, x3, y3);
		logic [31:0] t;
		logic signed [63:0] ax, ay, bx, by, cx, cy, dx, dy, ex, ey, px, py;
		int n;
		point_t p;
		n = 0;
		for (int k = 1; k <= 64; k++) begin
			t = k * step_q16;
			if (t > 32'h10000)
				break;
			ax = lerp_q16(x0, x1, t[16:0]);
			ay = lerp_q16(y0, y1, t[16:0]);
			if (cubic) begin
				bx = lerp_q16(x1, x2, t[16:0]);
				by = lerp_q16(y1, y2, t[16:0]);
				cx = lerp_q16(x2, x3, t[16:0]);
				cy = lerp_q16(y2, y3, t[16:0]);
				dx = lerp_q16(ax, bx, t[16:0]);
				dy = lerp_q16(ay, by, t[16:0]);
				ex = lerp_q16(bx, cx, t[16:0]);
				ey = lerp_q16(by, cy, t[16:0]);
			end else begin
				dx = ax;
				dy = ay;
				ex = lerp_q16(x1, x3, t[16:0]);
				ey = lerp_q16(y1, y3, t[16:0]);
			end
			px = lerp_q16(dx, ex, t[16:0]);
			py = lerp_q16(dy, ey, t[16:0]);
			p = '{px[31:0], py[31:0], colour, 1'b1, 1'b0};
			expected_points.insert(expected_points.size(), p);
			n++;
		end
		if (n > 0)
			expected_points[expected_points.size() - 1].last = 1'b1;
	endtask

	// advance the path state by one command and queue its points
	task automatic flatten_command(cmd_t c);
		logic signed [31:0] ox, oy, nx, ny, ax, ay, bx, by;
		point_t p;
		ox = c.absolute ? 32'sd0 : cur_x;
		oy = c.absolute ? 32'sd0 : cur_y;
		case (c.op)
			OP_MOVE, OP_LINE, OP_HORIZ, OP_VERT, OP_CLOSE: begin
				nx = $signed(c.v[0]) + ox;
				ny = $signed(c.v[1]) + oy;
				if (c.op == OP_HORIZ)
					ny = cur_y;
				if (c.op == OP_VERT) begin
					nx = cur_x;
					ny = $signed(c.v[0]) + oy;
				end
				if (c.op == OP_CLOSE) begin
					nx = start_x;
					ny = start_y;
				end
				if (c.op == OP_MOVE) begin
					start_x = nx;
					start_y = ny;
				end
				p = '{nx, ny, c.colour, c.op != OP_MOVE, 1'b1};
				expected_points.insert(expected_points.size(), p);
				cur_x = nx; cur_y = ny; ctl_x = nx; ctl_y = ny;
			end
			OP_CUBIC, OP_SCUBIC: begin
				if (c.op == OP_CUBIC) begin
					ax = $signed(c.v[0]) + ox; ay = $signed(c.v[1]) + oy;
					bx = $signed(c.v[2]) + ox; by = $signed(c.v[3]) + oy;
					nx = $signed(c.v[4]) + ox; ny = $signed(c.v[5]) + oy;
				end else begin
					ax = 2 * cur_x - ctl_x; ay = 2 * cur_y - ctl_y;
					bx = $signed(c.v[0]) + ox; by = $signed(c.v[1]) + oy;
					nx = $signed(c.v[2]) + ox; ny = $signed(c.v[3]) + oy;
				end
				bezier_points(1, c.colour, cur_x, cur_y, ax, ay, bx, by, nx, ny);
				ctl_x = bx; ctl_y = by; cur_x = nx; cur_y = ny;
			end
			OP_QUAD, OP_SQUAD: begin
				if (c.op == OP_QUAD) begin
					bx = $signed(c.v[0]) + ox; by = $signed(c.v[1]) + oy;
					nx = $signed(c.v[2]) + ox; ny = $signed(c.v[3]) + oy;
				end else begin
					bx = 2 * cur_x - ctl_x; by = 2 * cur_y - ctl_y;
					nx = $signed(c.v[0]) + ox; ny = $signed(c.v[1]) + oy;
				end
				bezier_points(0, c.colour, cur_x, cur_y, bx, by, 32'sd0, 32'sd0,
					nx, ny);
				ctl_x = bx; ctl_y = by; cur_x = nx; cur_y = ny;
			end
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $signed($urandom_range(0, 400 << 16)) - (200 << 16);
		endcase
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			c.op = 4'($urandom_range(9, 15));
		else
			c.op = 4'($urandom_range(0, 8));
		c.absolute = 1'($urandom_range(0, 1));
		c.colour = 24'($urandom);
		foreach (c.v[i])
			c.v[i] = rand_coord();
		return c;
	endfunction

	// send one command beat; prediction made on acceptance
	task automatic send_command(cmd_t c);
		while (!tx_no_idle && $urandom_range(0, 99) < 24)
			@(negedge clk);
		s_axis_tdata = {c.v[5], c.v[4], c.v[3], c.v[2], c.v[1], c.v[0], c.colour};
		s_axis_tuser = {c.absolute, c.op};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		accept_base = expected_points.size();
		flatten_command(c);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain_and_settle();
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_step(logic [16:0] value);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		step_q16 = value;
	endtask

	// directed table: op, abs, colour, v0..v5
	cmd_t directed [] ;
	point_t directed_first [int];

	initial begin
		cmd_t c;
		logic [16:0] steps [6];
		steps = '{17'd65536, 17'd1024, 17'd21845, 17'd65537, 17'd0, 17'd16384};
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		rx_no_idle = 1'b0;
		tx_no_idle = 1'b0;
		done = 1'b0;
		mismatches = 0;
		accept_base = 0;
		cur_x = 0; cur_y = 0; start_x = 0; start_y = 0; ctl_x = 0; ctl_y = 0;
		step_q16 = T_STEP_RESET;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		directed = new[14];
		directed[0]  = '{OP_MOVE,   1, 24'hFFFFFF, '{32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0}};
		directed[1]  = '{OP_LINE,   0, 24'h000000, '{32'h00000001, 32'hFFFFFFFF, 0, 0, 0, 0}};
		directed[2]  = '{OP_HORIZ,  1, 24'h123456, '{32'h00010000, 0, 0, 0, 0, 0}};
		directed[3]  = '{OP_VERT,   0, 24'h654321, '{32'hFFFF0000, 0, 0, 0, 0, 0}};
		directed[4]  = '{OP_CLOSE,  1, 24'hABCDEF, '{0, 0, 0, 0, 0, 0}};
		directed[5]  = '{OP_MOVE,   1, 24'h0000FF, '{0, 0, 0, 0, 0, 0}};
		directed[6]  = '{OP_CUBIC,  1, 24'h00FF00, '{32'h00100000, 0, 32'h00100000,
			32'h00100000, 32'h00200000, 32'h00100000}};
		directed[7]  = '{OP_SCUBIC, 0, 24'hFF0000, '{32'h00050000, 32'h00050000,
			32'h000A0000, 0, 0, 0}};
		directed[8]  = '{OP_QUAD,   0, 24'h808080, '{32'h00030000, 32'h00070000,
			32'h00060000, 0, 0, 0}};
		directed[9]  = '{OP_SQUAD,  1, 24'h7F7F7F, '{32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0}};
		directed[10] = '{4'd9,      1, 24'h111111, '{1, 2, 3, 4, 5, 6}};
		directed[11] = '{4'd15,     0, 24'h222222, '{1, 2, 3, 4, 5, 6}};
		directed[12] = '{OP_CUBIC,  0, 24'hFFFFFF, '{32'hFFFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h00000001, 32'hFFFFFFFF, 32'h80000000}};
		directed[13] = '{OP_LINE,   1, 24'h000001, '{32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0}};
		// points that can be read off directly
		directed_first[0]  = '{32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 1'b0, 1'b1};
		directed_first[4]  = '{32'h7FFFFFFF, 32'h80000000, 24'hABCDEF, 1'b1, 1'b1};
		directed_first[5]  = '{32'h0, 32'h0, 24'h0000FF, 1'b0, 1'b1};
		directed_first[13] = '{32'h80000000, 32'h7FFFFFFF, 24'h000001, 1'b1, 1'b1};

		// directed walk at the reset step
		for (int i = 0; i < directed.size(); i++) begin
			send_command(directed[i]);
			if (directed_first.exists(i)
				&& expected_points[accept_base] !== directed_first[i]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: predicted %h, typed %h", i,
						expected_points[accept_base], directed_first[i]);
			end
		end
		drain_and_settle();

		// random phases across several step settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			write_step(steps[ph]);
			tx_no_idle = (ph == 2);
			rx_no_idle = (ph == 2);
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				c = random_command();
				send_command(c);
			end
			drain_and_settle();
		end
		write_step(T_STEP_RESET);
		for (int i = 0; i < 10; i++)
			send_command(random_command());
		drain_and_settle();
		done = 1'b1;
	end

	// long receiver hold-off so the input side backs up
	initial begin
		rx_hold = 1'b0;
		wait (arst_n);
		repeat (300) @(negedge clk);
		rx_hold = 1'b1;
		repeat (2000) @(negedge clk);
		rx_hold = 1'b0;
	end

	// receiver ready
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = !rx_hold && (rx_no_idle || $urandom_range(0, 99) >= 24);
		end
	end

	// compare accepted points with the oldest prediction
	always @(posedge clk) begin
		point_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[87:64],
				m_axis_tuser, m_axis_tlast};
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected point beat %h", got);
			end else begin
				want = expected_points.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("point mismatch: x %h/%h y %h/%h rgb %h/%h pen %b/%b last %b/%b",
							want.x, got.x, want.y, got.y, want.colour, got.colour,
							want.pen, got.pen, want.last, got.last);
				end
			end
		end
	end

	// end of run and watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (done) begin
				if (mismatches == 0 && expected_points.size() == 0)
					$display("SCOREBOARD CLEAN");
				else
					$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (cycles >= CYCLE_CAP) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
rtl/spf_pkg.sv
rtl/spf_lerp.sv
rtl/svg_path_flattener.sv
bench/svg_path_flattener_tb.sv
